>>> design/tgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types and constants of the text glyph row renderer: opcodes,
// result status codes, configuration register indexes, the address unit
// request struct and the result beat struct.
// ----------------------------------------------------------------------------
package tgr_pkg;

    // Glyph geometry defaults and the fixed glyph width
    localparam int GLYPH_COUNT_DEF  = 256;
    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int GLYPH_WIDTH      = 8;

    // Field widths of the streams
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;

    // Colour ranges per pixel depth
    localparam logic [23:0] MAX_24BPP = 24'h00ffffff;
    localparam logic [23:0] MAX_16BPP = 24'h0000ffff;
    localparam logic [23:0] MAX_8BPP  = 24'h000000ff;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_DRAW    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ROW       = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_LOADED    = 3'd3,
        ST_RESTARTED = 3'd4,
        ST_BAD_START = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X   = 3'd0,
        CFG_START_Y   = 3'd1,
        CFG_OVF_MODE  = 3'd2,
        CFG_FG        = 3'd3,
        CFG_BG        = 3'd4,
        CFG_BPP       = 3'd5,
        CFG_X_RES     = 3'd6,
        CFG_Y_RES     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OVF_STOP    = 2'd0,
        OVF_START_X = 2'd1,
        OVF_ZERO    = 2'd2,
        OVF_NONE    = 2'd3
    } t_ovf_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_BASE,
        S_SCALE,
        S_ROWS
    } t_state;

    // Address unit commands: stride = a * b or acc = a * b + c per command
    typedef enum logic [2:0] {
        AU_HOLD,
        AU_STRIDE,
        AU_BASE,
        AU_SCALE,
        AU_STEP
    } t_au_cmd;

    typedef struct packed {
        t_au_cmd     cmd;
        logic [11:0] y;
        logic [11:0] x;
        logic [11:0] xres;
        logic [2:0]  bytes;
    } t_au_req;

    // One result beat; the last member sits in the lowest bits
    typedef struct packed {
        logic        halted;
        logic [23:0] bg_value;
        logic [23:0] fg_value;
        logic [7:0]  write_bits;
        logic [7:0]  fg_bits;
        logic [25:0] row_address;
        t_status     status;
    } t_out_beat;

endpackage

>>> design/text_glyph_row_renderer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_row_renderer_unit
// Bitmap font character generator for 8-pixel-wide glyphs. Loads font rows,
// draws characters as one result per glyph row and keeps the text cursor.
//
//   Channel   Direction  Beat contents (lowest bits first)
//   s_axis    in         opcode, char_code, glyph_row, row_pattern
//   m_axis    out        status, row_address, fg_bits, write_bits, fg_value,
//                        bg_value, halted; tlast = last
//   cfg       in         register index, 32-bit write data
//
// A load, restart, stopped or skipped draw is answered from the decision state.
// A drawn character passes the decision state, where the shared multiply-add
// unit forms the row stride, two unit passes for the first row address, then
// one row a cycle from the font RAM's registered read unless the output stalls.
// One item is in work at a time; the input is ready only when idle.
// A stalled output holds a single-beat answer in the decision state and holds
// the row state; reset clears cursor and flags but not the font RAM.
// ----------------------------------------------------------------------------
module text_glyph_row_renderer_unit #(
    parameter int GLYPH_COUNT  = tgr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_HEIGHT = tgr_pkg::GLYPH_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // opcode[1:0], char_code[9:2], glyph_row[13:10], row_pattern[21:14]
    input  logic [tgr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // status[2:0], row_address[28:3], fg_bits[36:29], write_bits[44:37],
    // fg_value[68:45], bg_value[92:69], halted[93]
    output logic [tgr_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tvalid,
    output logic                            o_m_tlast,
    input  logic                            i_m_tready,
    input  logic                            i_cfg_wr_en,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import tgr_pkg::*;

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int ROW_W      = $clog2(GLYPH_HEIGHT);

    // Configuration registers
    logic [11:0] r_start_x, r_start_y, r_x_res, r_y_res;
    logic [1:0]  r_ovf_mode;
    logic [31:0] r_fg, r_bg;
    logic [5:0]  r_bpp;

    // Sequencer and item registers
    t_state      r_state, n_state;
    t_opcode     r_op, n_op;
    logic [7:0]  r_ch, n_ch;
    logic [3:0]  r_gr, n_gr;
    logic [7:0]  r_pat, n_pat;
    logic [11:0] r_cx, n_cx, r_cy, n_cy;
    logic [11:0] r_x0, n_x0, r_y0, n_y0;
    logic        r_stopped, n_stopped;
    logic [23:0] r_fv, n_fv, r_bv, n_bv;
    logic        r_bg_ok, n_bg_ok, r_known, n_known, r_blank, n_blank;
    logic [ROW_W-1:0] r_row, n_row;
    logic        r_out_valid, n_out_valid, r_out_last, n_out_last;
    t_out_beat   r_out, n_out;

    // Datapath helpers
    logic             slot_free;
    logic             fits, row_last;
    logic [11:0]      ex, ey, e_cx, e_cy;
    logic             e_stop, bad_start;
    logic [23:0]      maxv, fv_calc, bv_calc;
    logic             known_calc, bg_ok_calc;
    logic             ram_we, ram_re;
    logic [FONT_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_rdata, row_bits;
    t_au_req          au_req;
    logic [25:0]      au_acc;

    function automatic logic [FONT_AW-1:0] font_addr(input logic [7:0] ch,
                                                      input logic [ROW_W-1:0] row);
        font_addr = FONT_AW'(int'(ch) * GLYPH_HEIGHT + int'(row));
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_ovf_mode <= OVF_START_X;
            r_fg       <= 32'h00ffffff;
            r_bg       <= '0;
            r_bpp      <= 6'd32;
            r_x_res    <= 12'd800;
            r_y_res    <= 12'd480;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_X:  r_start_x  <= i_cfg_data[11:0];
                CFG_START_Y:  r_start_y  <= i_cfg_data[11:0];
                CFG_OVF_MODE: r_ovf_mode <= i_cfg_data[1:0];
                CFG_FG:       r_fg       <= i_cfg_data;
                CFG_BG:       r_bg       <= i_cfg_data;
                CFG_BPP:      r_bpp      <= i_cfg_data[5:0];
                CFG_X_RES:    r_x_res    <= i_cfg_data[11:0];
                CFG_Y_RES:    r_y_res    <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Colour clamping to the pixel depth
    always_comb begin
        known_calc = 1'b1;
        case (r_bpp)
            6'd32, 6'd24: maxv = MAX_24BPP;
            6'd16:        maxv = MAX_16BPP;
            6'd8:         maxv = MAX_8BPP;
            default: begin
                maxv       = '0;
                known_calc = 1'b0;
            end
        endcase
        if (!known_calc || r_fg[31]) begin
            fv_calc = '0;
        end else if (r_fg[30:0] > {7'd0, maxv}) begin
            fv_calc = maxv;
        end else begin
            fv_calc = r_fg[23:0];
        end
        bg_ok_calc = known_calc && !r_bg[31] && (r_bg[30:0] <= {7'd0, maxv});
        bv_calc    = bg_ok_calc ? r_bg[23:0] : '0;
    end

    // Fit test and right-edge / bottom rules
    always_comb begin
        fits = (({1'b0, r_cx} + 13'(GLYPH_WIDTH)) <= {1'b0, r_x_res}) &&
               (({1'b0, r_cy} + 13'(GLYPH_HEIGHT)) <= {1'b0, r_y_res});
        ex     = fits ? (r_cx + 12'(GLYPH_WIDTH)) : r_cx;
        ey     = r_cy;
        e_cx   = ex;
        e_cy   = ey;
        e_stop = r_stopped;
        if (({1'b0, ex} + 13'(GLYPH_WIDTH)) >= {1'b0, r_x_res}) begin
            unique case (t_ovf_mode'(r_ovf_mode))
                OVF_STOP: e_stop = 1'b1;
                OVF_START_X: begin
                    e_cx = r_start_x;
                    e_cy = ey + 12'(GLYPH_HEIGHT);
                end
                OVF_ZERO: begin
                    e_cx = '0;
                    e_cy = ey + 12'(GLYPH_HEIGHT);
                end
                default: begin
                end
            endcase
        end
        if (({1'b0, e_cy} + 13'(GLYPH_HEIGHT)) > {1'b0, r_y_res}) begin
            e_stop = 1'b1;
        end
        bad_start = (({1'b0, r_start_x} + 13'(GLYPH_WIDTH)) > {1'b0, r_x_res}) ||
                    (({1'b0, r_start_y} + 13'(GLYPH_HEIGHT)) > {1'b0, r_y_res});
    end

    assign slot_free = !r_out_valid || i_m_tready;
    assign row_last  = (r_row == ROW_W'(GLYPH_HEIGHT - 1));
    assign row_bits  = r_blank ? 8'd0 : ram_rdata;

    // Sequencer: next state, item handling and output beat
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ch        = r_ch;
        n_gr        = r_gr;
        n_pat       = r_pat;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_stopped   = r_stopped;
        n_fv        = r_fv;
        n_bv        = r_bv;
        n_bg_ok     = r_bg_ok;
        n_known     = r_known;
        n_blank     = r_blank;
        n_row       = r_row;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_last  = r_out_last;
        n_out       = r_out;
        o_s_tready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = font_addr(r_ch, r_gr[ROW_W-1:0]);
        ram_re      = 1'b0;
        ram_raddr   = font_addr(r_ch, '0);
        au_req      = '{cmd: AU_HOLD, y: r_y0, x: r_x0, xres: r_x_res, bytes: r_bpp[5:3]};

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_op    = t_opcode'(i_s_tdata[1:0]);
                    n_ch    = i_s_tdata[9:2];
                    n_gr    = i_s_tdata[13:10];
                    n_pat   = i_s_tdata[21:14];
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (r_op)
                    OP_LOAD: begin
                        if (slot_free) begin
                            ram_we = (int'(r_ch) < GLYPH_COUNT) &&
                                     (int'(r_gr) < GLYPH_HEIGHT);
                            n_out       = '0;
                            n_out.status = ST_LOADED;
                            n_out.halted = r_stopped;
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    OP_RESTART: begin
                        if (slot_free) begin
                            n_cx        = r_start_x;
                            n_cy        = r_start_y;
                            n_stopped   = bad_start;
                            n_out       = '0;
                            n_out.status = bad_start ? ST_BAD_START : ST_RESTARTED;
                            n_out.halted = bad_start;
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    OP_DRAW: begin
                        if (r_stopped) begin
                            if (slot_free) begin
                                n_out        = '0;
                                n_out.status = ST_IGNORED;
                                n_out.halted = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_last   = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end else if (!fits) begin
                            if (slot_free) begin
                                n_cx         = e_cx;
                                n_cy         = e_cy;
                                n_stopped    = e_stop;
                                n_out        = '0;
                                n_out.status = ST_SKIPPED;
                                n_out.halted = e_stop;
                                n_out_valid  = 1'b1;
                                n_out_last   = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            // Character fits: latch its context and start the address
                            n_x0       = r_cx;
                            n_y0       = r_cy;
                            n_cx       = e_cx;
                            n_cy       = e_cy;
                            n_stopped  = e_stop;
                            n_fv       = fv_calc;
                            n_bv       = bv_calc;
                            n_bg_ok    = bg_ok_calc;
                            n_known    = known_calc;
                            n_blank    = !(int'(r_ch) < GLYPH_COUNT);
                            au_req.cmd = AU_STRIDE;
                            n_state    = S_BASE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_BASE: begin
                au_req.cmd = AU_BASE;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                au_req.cmd = AU_SCALE;
                ram_re     = 1'b1;
                ram_raddr  = font_addr(r_ch, '0);
                n_row      = '0;
                n_state    = S_ROWS;
            end
            S_ROWS: begin
                if (slot_free) begin
                    n_out.status      = ST_ROW;
                    n_out.row_address = au_acc;
                    n_out.fg_bits     = row_bits;
                    n_out.write_bits  = r_known ? (r_bg_ok ? 8'hff : row_bits) : 8'd0;
                    n_out.fg_value    = r_fv;
                    n_out.bg_value    = r_bv;
                    n_out.halted      = r_stopped;
                    n_out_valid       = 1'b1;
                    n_out_last        = row_last;
                    au_req.cmd        = AU_STEP;
                    if (row_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row     = r_row + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = font_addr(r_ch, r_row + 1'b1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cx        <= '0;
            r_cy        <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_gr       <= n_gr;
        r_pat      <= n_pat;
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_fv       <= n_fv;
        r_bv       <= n_bv;
        r_bg_ok    <= n_bg_ok;
        r_known    <= n_known;
        r_blank    <= n_blank;
        r_row      <= n_row;
        r_out_last <= n_out_last;
        r_out      <= n_out;
    end

    tgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (r_pat),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    tgr_addr_unit u_addr_unit (
        .i_clk (i_clk),
        .i_req (au_req),
        .o_acc (au_acc)
    );

    assign o_m_tdata  = {2'b00, r_out};
    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;

    // An accepted item always moves the sequencer to its decision cycle
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && i_s_tvalid) |=> (r_state == S_DECIDE))
        else $error("accepted item did not reach the decision cycle");

    // Glyph rows go out without gaps once the first row has been taken
    a_rows_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast && (r_out.status == ST_ROW))
        |=> (o_m_tvalid && (r_out.status == ST_ROW)))
        else $error("gap or foreign beat inside a glyph row burst");

    // Every beat that is not a glyph row closes its item
    a_single_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_out.status != ST_ROW)) |-> o_m_tlast)
        else $error("single-beat result without tlast");

    // The row counter stays inside the glyph
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROWS) |-> (int'(r_row) < GLYPH_HEIGHT))
        else $error("row counter beyond the glyph height");

endmodule

>>> design/tgr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/tgr_addr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_addr_unit
// Shared multiply-add unit that builds the framebuffer row addresses. It
// forms the row stride, the first row's byte offset and then steps by the
// stride once per row.
// ----------------------------------------------------------------------------
module tgr_addr_unit (
    input  logic             i_clk,
    input  tgr_pkg::t_au_req i_req,
    output logic [25:0]      o_acc
);

    import tgr_pkg::*;

    logic [24:0] op_a;
    logic [11:0] op_b;
    logic [25:0] op_c;
    logic [36:0] product;
    logic [25:0] r_acc, n_acc;
    logic [14:0] r_stride, n_stride;

    // Operand selection for the single multiplier
    always_comb begin
        op_a     = '0;
        op_b     = '0;
        op_c     = '0;
        n_acc    = r_acc;
        n_stride = r_stride;
        case (i_req.cmd)
            AU_STRIDE: begin
                op_a = {13'd0, i_req.xres};
                op_b = {9'd0, i_req.bytes};
            end
            AU_BASE: begin
                op_a = {13'd0, i_req.y};
                op_b = i_req.xres;
                op_c = {14'd0, i_req.x};
            end
            AU_SCALE: begin
                op_a = r_acc[24:0];
                op_b = {9'd0, i_req.bytes};
            end
            AU_STEP: begin
                op_a = {10'd0, r_stride};
                op_b = 12'd1;
                op_c = r_acc;
            end
            default: begin
            end
        endcase
        product = op_a * op_b;
        if (i_req.cmd == AU_STRIDE) begin
            n_stride = product[14:0];
        end else if (i_req.cmd != AU_HOLD) begin
            n_acc = product[25:0] + op_c;
        end
    end

    // Accumulator and stride registers
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_stride <= n_stride;
    end

    assign o_acc = r_acc;

endmodule
